@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Implication checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ebq_pkg.sv @@
// Shared types and constants for the encoder and button qualifier.
// No dependencies; imported by the encoder, button, top-level and tick checker modules.
package ebq_pkg;

	// Field and register widths
	localparam int TIME_W     = 32;
	localparam int POLL_W     = 8;
	localparam int DEBOUNCE_W = 10;
	localparam int LONG_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [POLL_W-1:0]     POLL_RESET     = 8'd20;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd30;
	localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd700;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLL_PERIOD = 2'd0,
		REG_DEBOUNCE    = 2'd1,
		REG_LONG_PRESS  = 2'd2
	} cfg_reg_t;

	// Rotation step codes
	localparam logic signed [1:0] ROT_NONE = 2'sb00;
	localparam logic signed [1:0] ROT_CW   = 2'sb01;
	localparam logic signed [1:0] ROT_CCW  = 2'sb11;

	typedef struct packed {
		logic [POLL_W-1:0]     poll_period;
		logic [DEBOUNCE_W-1:0] debounce;
		logic [LONG_W-1:0]     long_press;
	} cfg_t;

	typedef struct packed {
		logic long_press_event;
		logic click_event;
		logic click_short;
		logic button_held;
	} btn_result_t;

endpackage

@@ rtl/ebq_encoder.sv @@
// Encoder step decoder: one step per CLK edge, direction from DT.
// Depends on ebq_pkg.
module ebq_encoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic              enc_clk,
	input  logic              enc_dt,
	output logic signed [1:0] rotate_step
);
	import ebq_pkg::*;

	logic clk_prev_q;

	// Step on any CLK change; same level as DT means clockwise
	always_comb begin
		rotate_step = ROT_NONE;
		if (enc_clk != clk_prev_q) begin
			rotate_step = (enc_clk == enc_dt) ? ROT_CW : ROT_CCW;
		end
	end

	// Pin idles pulled up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_prev_q <= 1'b1;
		end else if (step_en) begin
			clk_prev_q <= enc_clk;
		end
	end

endmodule

@@ rtl/ebq_button.sv @@
// Button qualifier: tick counter, poll timer, debounce and long press.
// Depends on ebq_pkg.
module ebq_button (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  ebq_pkg::cfg_t       cfg,
	input  logic                button_raw,
	input  logic                long_press_accepted,
	output ebq_pkg::btn_result_t result
);
	import ebq_pkg::*;

	logic [TIME_W-1:0] tick_q;
	logic [TIME_W-1:0] poll_stamp_q;
	logic [TIME_W-1:0] raw_stamp_q;
	logic [TIME_W-1:0] press_stamp_q;
	logic              raw_prev_q;
	logic              stable_q;
	logic              long_done_q;

	logic [TIME_W-1:0] poll_age;
	logic [TIME_W-1:0] raw_age;
	logic [TIME_W-1:0] press_age;
	logic              poll;
	logic              raw_change;
	logic              raw_prev_n;
	logic              long_fire;
	logic              long_done_mid;
	logic              settle;
	logic              press;
	logic              release_ev;
	logic              press_long;

	// Elapsed times, all modulo 2^32
	assign poll_age  = tick_q - poll_stamp_q;
	assign raw_age   = raw_change ? '0 : (tick_q - raw_stamp_q);
	assign press_age = tick_q - press_stamp_q;
	assign press_long = press_age >= TIME_W'(cfg.long_press);

	// Poll gate and raw level tracking
	assign poll       = poll_age >= TIME_W'(cfg.poll_period);
	assign raw_change = poll && (button_raw != raw_prev_q);
	assign raw_prev_n = poll ? button_raw : raw_prev_q;

	// Long press fires once per press, only when the screen takes it
	assign long_fire = poll && !stable_q && !long_done_q && long_press_accepted
		&& press_long;
	assign long_done_mid = long_done_q || long_fire;

	// Debounced level change
	assign settle = poll && (raw_age >= TIME_W'(cfg.debounce)) && (stable_q != raw_prev_n);
	assign press      = settle && !raw_prev_n;
	assign release_ev = settle && raw_prev_n;

	always_comb begin
		result.long_press_event = long_fire;
		result.click_event      = release_ev && !long_done_mid;
		result.click_short      = release_ev && !long_done_mid && !press_long;
		result.button_held      = settle ? !raw_prev_n : !stable_q;
	end

	// State update, one beat per enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			poll_stamp_q  <= '0;
			raw_stamp_q   <= '0;
			press_stamp_q <= '0;
			raw_prev_q    <= 1'b1;
			stable_q      <= 1'b1;
			long_done_q   <= 1'b0;
		end else if (step_en) begin
			tick_q <= tick_q + TIME_W'(1);
			if (poll) begin
				poll_stamp_q <= tick_q;
			end
			if (raw_change) begin
				raw_stamp_q <= tick_q;
			end
			raw_prev_q <= raw_prev_n;
			if (settle) begin
				stable_q <= raw_prev_n;
			end
			if (press) begin
				press_stamp_q <= tick_q;
				long_done_q   <= 1'b0;
			end else begin
				long_done_q <= long_done_mid;
			end
		end
	end

endmodule

@@ rtl/encoder_button_qualifier.sv @@
// Top level of the rotary encoder and push button qualifier.
// Depends on ebq_pkg, ebq_encoder and ebq_button.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per millisecond tick with the
//   encoder CLK and DT levels, the raw active-low button and whether the
//   current screen takes a long press.
//   Output channel (out_valid/out_ready): exactly one beat per input beat, in
//   order: rotation step (+1, -1, 0), long press and click events, click short
//   flag and the debounced held level.
//   Config channel (cfg_valid/cfg_ready): always ready; index 0 poll period,
//   1 debounce time, 2 long press time; other indexes are ignored. Write only
//   while no beat is in flight.
// Path: an accepted beat is held in the input register, then loaded into the
//   output register once that is free, and its result is taken from there.
// Throughput: one beat per cycle while out_ready is high; the input register,
//   a single pass of compare logic and the output register set the rate.
// Reset: all timers and stamps clear, pin and button levels read released,
//   registers return to 20 / 30 / 700 ticks.
// Stall: while out_ready is low the output beat holds; one more input beat
//   is held in the input register, after which in_ready drops.
module encoder_button_qualifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           enc_clk,
	input  logic                           enc_dt,
	input  logic                           button_raw,
	input  logic                           long_press_accepted,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [1:0]              rotate_step,
	output logic                           long_press_event,
	output logic                           click_event,
	output logic                           click_short,
	output logic                           button_held,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ebq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ebq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ebq_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic              enc_clk_s1;
	logic              enc_dt_s1;
	logic              button_raw_s1;
	logic              accepted_s1;
	logic              advance;
	logic signed [1:0] step;
	btn_result_t       btn;
	logic              valid_s2;
	logic signed [1:0] rotate_step_s2;
	btn_result_t       btn_s2;

	// Register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_period <= POLL_RESET;
			cfg_q.debounce    <= DEBOUNCE_RESET;
			cfg_q.long_press  <= LONG_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_POLL_PERIOD: cfg_q.poll_period <= cfg_data[POLL_W-1:0];
				REG_DEBOUNCE:    cfg_q.debounce    <= cfg_data[DEBOUNCE_W-1:0];
				REG_LONG_PRESS:  cfg_q.long_press  <= cfg_data[LONG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Stage handshake: s1 moves on when the output register frees up
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			enc_clk_s1    <= enc_clk;
			enc_dt_s1     <= enc_dt;
			button_raw_s1 <= button_raw;
			accepted_s1   <= long_press_accepted;
		end
	end

	ebq_encoder u_encoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.enc_clk     (enc_clk_s1),
		.enc_dt      (enc_dt_s1),
		.rotate_step (step)
	);

	ebq_button u_button (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step_en             (advance),
		.cfg                 (cfg_q),
		.button_raw          (button_raw_s1),
		.long_press_accepted (accepted_s1),
		.result              (btn)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rotate_step_s2 <= step;
			btn_s2         <= btn;
		end
	end

	assign out_valid        = valid_s2;
	assign rotate_step      = rotate_step_s2;
	assign long_press_event = btn_s2.long_press_event;
	assign click_event      = btn_s2.click_event;
	assign click_short      = btn_s2.click_short;
	assign button_held      = btn_s2.button_held;

endmodule

@@ rtl/ebq_checker.sv @@
// Port-level checker for encoder_button_qualifier, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ebq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [1:0] rotate_step,
	input logic              long_press_event,
	input logic              click_event,
	input logic              click_short,
	input logic              button_held
);

	// A stalled result beat holds its step, click event and held level
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(rotate_step) && $stable(click_event) && $stable(button_held), "stalled output beat changed")

	// Short flag only rides on a click
	`ASSERT_CLK(a_short_click, out_valid && click_short |-> click_event, "click_short without click")

	// A press taken as long press never also yields a click
	`ASSERT_CLK(a_long_no_click, out_valid && long_press_event |-> !click_event, "long press and click together")

	// Step is +1, -1 or 0
	`ASSERT_CLK(a_step_range, out_valid |-> rotate_step != 2'sb10, "rotation step out of range")

endmodule

bind encoder_button_qualifier ebq_checker u_ebq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.rotate_step      (rotate_step),
	.long_press_event (long_press_event),
	.click_event      (click_event),
	.click_short      (click_short),
	.button_held      (button_held)
);

@@ sim/ebq_tick_checker.sv @@
`timescale 1ns / 1ps
// Checker for the encoder and button qualifier: watches the config, input and
// output channels, predicts every output beat and compares it in order.
// Depends on ebq_pkg.
module ebq_tick_checker
	import ebq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  enc_clk,
	input  logic                  enc_dt,
	input  logic                  button_raw,
	input  logic                  long_press_accepted,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic signed [1:0]     rotate_step,
	input  logic                  long_press_event,
	input  logic                  click_event,
	input  logic                  click_short,
	input  logic                  button_held,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic signed [1:0] rotate;
		btn_result_t       btn;
	} tick_result_t;

	// Shadow registers and qualifier state
	cfg_t              settings;
	logic [TIME_W-1:0] tick_count;
	logic [TIME_W-1:0] poll_stamp;
	logic [TIME_W-1:0] raw_change_stamp;
	logic [TIME_W-1:0] press_start_stamp;
	logic              clk_prev;
	logic              raw_prev;
	logic              stable_level;
	logic              long_done;

	tick_result_t expected_ticks[$];
	int           error_count = 0;
	int           pending_count = 0;

	assign mismatches  = error_count;
	assign outstanding = pending_count;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		$display("%0t ns: tick mismatch on %s: got %0d, expected %0d", $time, what, got_v,
			want_v);
		error_count++;
	endtask

	// One millisecond tick of the encoder and button logic
	task automatic qualify_tick(input logic c, input logic d, input logic raw, input logic acc,
			output tick_result_t r);
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] since_poll;
		logic [TIME_W-1:0] since_change;
		logic [TIME_W-1:0] held_for;
		now = tick_count;
		r = '0;
		r.rotate = ROT_NONE;

		// every CLK edge is one detent
		if (c != clk_prev) begin
			r.rotate = (c == d) ? ROT_CW : ROT_CCW;
			clk_prev = c;
		end

		since_poll = now - poll_stamp;
		if (since_poll >= TIME_W'(settings.poll_period)) begin
			poll_stamp = now;
			if (raw != raw_prev) begin
				raw_prev = raw;
				raw_change_stamp = now;
			end

			// long press fires once per accepted hold
			held_for = now - press_start_stamp;
			if (!stable_level && !long_done && acc &&
					held_for >= TIME_W'(settings.long_press)) begin
				r.btn.long_press_event = 1'b1;
				long_done = 1'b1;
			end

			// debounce, then press start or click on release
			since_change = now - raw_change_stamp;
			if (since_change >= TIME_W'(settings.debounce) && stable_level != raw_prev) begin
				stable_level = raw_prev;
				if (!stable_level) begin
					press_start_stamp = now;
					long_done = 1'b0;
				end else if (!long_done) begin
					r.btn.click_event = 1'b1;
					r.btn.click_short = (held_for < TIME_W'(settings.long_press));
				end
			end
		end

		tick_count = now + 1'b1;
		r.btn.button_held = ~stable_level;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		tick_result_t got;
		if (!arst_n) begin
			settings.poll_period = POLL_RESET;
			settings.debounce = DEBOUNCE_RESET;
			settings.long_press = LONG_RESET;
			tick_count = '0;
			poll_stamp = '0;
			raw_change_stamp = '0;
			press_start_stamp = '0;
			clk_prev = 1'b1;
			raw_prev = 1'b1;
			stable_level = 1'b1;
			long_done = 1'b0;
			expected_ticks.delete();
			pending_count <= 0;
		end else begin
			// register write beat
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POLL_PERIOD: settings.poll_period = cfg_data[POLL_W-1:0];
					REG_DEBOUNCE:    settings.debounce = cfg_data[DEBOUNCE_W-1:0];
					REG_LONG_PRESS:  settings.long_press = cfg_data[LONG_W-1:0];
					default: ;
				endcase
			end

			// output beat against the oldest prediction
			if (out_valid && out_ready) begin
				got.rotate = rotate_step;
				got.btn.long_press_event = long_press_event;
				got.btn.click_event = click_event;
				got.btn.click_short = click_short;
				got.btn.button_held = button_held;
				if (expected_ticks.size() == 0) begin
					report_mismatch("output beat with nothing pending", 1, 0);
				end else begin
					want = expected_ticks.pop_front();
					if (got.rotate !== want.rotate)
						report_mismatch("rotate_step", int'(got.rotate), int'(want.rotate));
					if (got.btn.long_press_event !== want.btn.long_press_event)
						report_mismatch("long_press_event", got.btn.long_press_event,
							want.btn.long_press_event);
					if (got.btn.click_event !== want.btn.click_event)
						report_mismatch("click_event", got.btn.click_event,
							want.btn.click_event);
					if (got.btn.click_short !== want.btn.click_short)
						report_mismatch("click_short", got.btn.click_short,
							want.btn.click_short);
					if (got.btn.button_held !== want.btn.button_held)
						report_mismatch("button_held", got.btn.button_held,
							want.btn.button_held);
				end
			end

			// input beat: predict its result
			if (in_valid && in_ready) begin
				qualify_tick(enc_clk, enc_dt, button_raw, long_press_accepted, want);
				expected_ticks.push_back(want);
			end
			pending_count <= expected_ticks.size();
		end
	end

endmodule

@@ sim/encoder_button_qualifier_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for encoder_button_qualifier: drives ticks, register writes and
// output stalls; ebq_tick_checker does the prediction. Depends on ebq_pkg.
module encoder_button_qualifier_tb;
	import ebq_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SPAN_CAP = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  enc_clk;
	logic                  enc_dt;
	logic                  button_raw;
	logic                  long_press_accepted;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [1:0]     rotate_step;
	logic                  long_press_event;
	logic                  click_event;
	logic                  click_short;
	logic                  button_held;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   mismatches;
	int   outstanding;
	int   items_sent = 0;
	int   cycles = 0;
	logic gaps_on = 1'b1;

	encoder_button_qualifier dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.enc_clk             (enc_clk),
		.enc_dt              (enc_dt),
		.button_raw          (button_raw),
		.long_press_accepted (long_press_accepted),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.rotate_step         (rotate_step),
		.long_press_event    (long_press_event),
		.click_event         (click_event),
		.click_short         (click_short),
		.button_held         (button_held),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	ebq_tick_checker tick_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.enc_clk             (enc_clk),
		.enc_dt              (enc_dt),
		.button_raw          (button_raw),
		.long_press_accepted (long_press_accepted),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.rotate_step         (rotate_step),
		.long_press_event    (long_press_event),
		.click_event         (click_event),
		.click_short         (click_short),
		.button_held         (button_held),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.mismatches          (mismatches),
		.outstanding         (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop if the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("encoder_button_qualifier_tb: errors");
			$finish;
		end
	end

	// Receiver: short and long stalls, with calm stretches of steady ready
	initial begin
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else if ($urandom_range(0, 99) < 2) begin
					calm_left = $urandom_range(40, 200);
				end else if ($urandom_range(0, 99) < 25) begin
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
						$urandom_range(1, 3);
				end
			end
		end
	end

	// One tick beat, preceded by a random gap when gaps are on
	task automatic send_tick(input logic c, input logic d, input logic raw, input logic acc);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 99) < 30)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 2);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		enc_clk <= c;
		enc_dt <= d;
		button_raw <= raw;
		long_press_accepted <= acc;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Stop sending until every result is back, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write beat; cfg_valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_settings(input logic [POLL_W-1:0] poll,
			input logic [DEBOUNCE_W-1:0] deb, input logic [LONG_W-1:0] hold);
		write_reg(REG_POLL_PERIOD, CFG_DATA_W'(poll));
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
		write_reg(REG_LONG_PRESS, CFG_DATA_W'(hold));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Button press/release segments with bounce, some pure noise, encoder turning
	task automatic press_sequences(input int count, input int span);
		int   quota;
		int   seg_len;
		int   bounce;
		int   acc_mode;
		logic level;
		logic c;
		logic d;
		logic raw;
		logic acc;
		quota = items_sent + count;
		level = button_raw;
		c = enc_clk;
		while (items_sent < quota) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			acc_mode = $urandom_range(0, 9);
			if ($urandom_range(0, 99) < 10) begin
				seg_len = $urandom_range(1, 8);
				bounce = seg_len;
			end else begin
				level = ~level;
				seg_len = $urandom_range(1, span);
				bounce = $urandom_range(0, 3);
			end
			for (int i = 0; i < seg_len && items_sent < quota; i++) begin
				if ($urandom_range(0, 2) == 0)
					c = ~c;
				d = 1'($urandom_range(0, 1));
				raw = (i < bounce) ? 1'($urandom_range(0, 1)) : level;
				if (acc_mode < 7)
					acc = 1'b1;
				else if (acc_mode < 9)
					acc = 1'b0;
				else
					acc = 1'($urandom_range(0, 1));
				send_tick(c, d, raw, acc);
			end
		end
	endtask

	initial begin
		int poll_set[7]  = '{0, 1, 3, 2, 255, 1, 20};
		int deb_set[7]   = '{0, 2, 5, 0, 1023, 1, 30};
		int long_set[7]  = '{0, 8, 20, 1, 65535, 4, 700};
		int count_set[7] = '{200, 300, 300, 200, 150, 250, 350};
		int span;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		enc_clk <= 1'b1;
		enc_dt <= 1'b1;
		button_raw <= 1'b1;
		long_press_accepted <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_POLL_PERIOD;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: both rotation directions, CLK held, accept low and high
		gaps_on = 1'b0;
		send_tick(1'b1, 1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1, 1'b1);
		settle();

		// Unmapped index is ignored; then poll every tick, no debounce, zero hold
		write_reg(REG_UNMAPPED, '1);
		program_settings(8'd0, 10'd0, 16'd0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1, 1'b0);
		settle();

		// Bouncy press then quick release: short click
		program_settings(8'd1, 10'd2, 16'd5);
		send_tick(1'b0, 1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1, 1'b1);
		settle();

		// Random phases over several settings, extremes included
		for (int p = 0; p < 7; p++) begin
			program_settings(POLL_W'(poll_set[p]), DEBOUNCE_W'(deb_set[p]),
				LONG_W'(long_set[p]));
			span = 2 * (poll_set[p] + deb_set[p] + long_set[p]) + 4;
			if (span > SPAN_CAP)
				span = SPAN_CAP;
			press_sequences(count_set[p], span);
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("encoder_button_qualifier_tb: clean");
		else
			$display("encoder_button_qualifier_tb: errors");
		$finish;
	end

endmodule

@@ encoder_button_qualifier.f @@
+incdir+rtl
rtl/ebq_pkg.sv
rtl/ebq_encoder.sv
rtl/ebq_button.sv
rtl/encoder_button_qualifier.sv
rtl/ebq_checker.sv
sim/ebq_tick_checker.sv
sim/encoder_button_qualifier_tb.sv
